// ===== hdl/dwfs_pkg.sv =====
// Package for the deviation weighted face selector.
// Beat types, field widths, constants, the sequencer state type and the raw_metric helper. No dependencies.
package dwfs_pkg;

    localparam int MAX_FACES_DEF = 16;

    localparam int ID_W   = 16;
    localparam int ST_W   = 3;
    localparam int RTT_W  = 40;
    localparam int PV_W   = 32;
    localparam int MW     = 40;
    localparam int NW     = 17;
    localparam int PROD_W = MW + NW;

    localparam logic [NW-1:0] Q_ONE     = 17'h10000;
    localparam logic [NW-1:0] EFF_RESET = 17'd62259;

    localparam logic [1:0] MET_ST = 2'd0;
    localparam logic [1:0] MET_RT = 2'd1;
    localparam logic [1:0] MET_PV = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  face_id;
        logic             is_arrival_face;
        logic [ST_W-1:0]  status_level;
        logic [RTT_W-1:0] rtt_ns;
        logic [PV_W-1:0]  pending_value;
        logic             last;
    } t_in_beat;

    typedef struct packed {
        logic [ID_W-1:0] chosen_face;
        logic            overflowed;
    } t_out_beat;

    typedef struct packed {
        logic [ID_W-1:0]  face_id;
        logic [ST_W-1:0]  status_level;
        logic [RTT_W-1:0] rtt_ns;
        logic [PV_W-1:0]  pending_value;
    } t_raw_word;

    typedef logic [2:0][NW-1:0] t_norm_word;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [MW-1:0]     den;
    } t_div_req;

    typedef enum logic [4:0] {
        S_IDLE, S_MM_RD, S_MM_ACC, S_GAP,
        S_NM_RD, S_NM_MUL, S_NM_DST, S_NM_DIV, S_NM_WR,
        S_PD_RDI, S_PD_LDI, S_PD_RDJ, S_PD_ACC,
        S_SC_RD, S_SC_MUL, S_SC_ADD, S_SC_CMP,
        S_ID_RD, S_EMIT
    } t_state;

    function automatic logic [MW-1:0] raw_metric(input t_raw_word w, input logic [1:0] k);
        logic [MW-1:0] r;
        case (k)
            MET_ST:  r = MW'(w.status_level);
            MET_RT:  r = MW'(w.rtt_ns);
            MET_PV:  r = MW'(w.pending_value);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/dwfs_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module dwfs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== hdl/dwfs_mul.sv =====
// Shared registered multiplier, 40 x 17 bits.
// Depends on dwfs_pkg.
module dwfs_mul (
    input  logic                          i_clk,
    input  logic [dwfs_pkg::MW-1:0]       i_a,
    input  logic [dwfs_pkg::NW-1:0]       i_b,
    output logic [dwfs_pkg::PROD_W-1:0]   o_p
);
    logic [dwfs_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= dwfs_pkg::PROD_W'(i_a) * dwfs_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;
endmodule

// ===== hdl/dwfs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, quotient at most 17 bits.
// Depends on dwfs_pkg.
module dwfs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dwfs_pkg::t_div_req         i_req,
    output logic                       o_done,
    output logic [dwfs_pkg::NW-1:0]    o_quot
);
    localparam int PW = dwfs_pkg::PROD_W;
    localparam int NW = dwfs_pkg::NW;

    logic [PW-1:0]   r_rem, n_rem;
    logic [PW-2:0]   r_dsh, n_dsh;
    logic [NW-1:0]   r_q, n_q;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_done, n_done;

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem = i_req.num;
            n_dsh = {i_req.den, 16'b0};
            n_cnt = 5'(NW);
        end else if (r_cnt != 5'd0) begin
            if (r_rem >= {1'b0, r_dsh}) begin
                n_rem = r_rem - {1'b0, r_dsh};
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt - 5'd1;
            n_done = (r_cnt == 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== hdl/deviation_weighted_face_selector.sv =====
// Top level of the deviation weighted face selector: face store, sequencer and datapath.
// Depends on dwfs_pkg, dwfs_ram, dwfs_mul, dwfs_div.
//
//  channel | signals                              | beat
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data  | efficacy, Q1.16
//  in      | i_in_valid, o_in_stall, i_in_data     | one candidate face
//  out     | o_out_valid, i_out_stall, o_out_data  | chosen face id, overflow flag
//
// Faces load one per cycle while o_in_stall is low. After a last beat with n stored faces
// the sequencer runs a min/max pass, the normalisation (17-step divider run three times
// per face), a pairwise pass over the single-read-port normalised memory and the weighted
// sums, plus gap and emit; a single face skips the pairwise pass. o_in_stall is high meanwhile.
// Reset is synchronous; an empty set produces no beat; a waiting result holds in the
// output register while i_out_stall is high.
module deviation_weighted_face_selector #(
    parameter int MaxFaces = dwfs_pkg::MAX_FACES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [dwfs_pkg::NW-1:0] i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  dwfs_pkg::t_in_beat      i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output dwfs_pkg::t_out_beat     o_out_data
);
    localparam int AW = $clog2(MaxFaces);
    localparam int CW = $clog2(MaxFaces + 1);
    localparam int VW = $clog2(MaxFaces * MaxFaces) + 17;
    localparam int SW = VW + 19;
    localparam int MW = dwfs_pkg::MW;
    localparam int NW = dwfs_pkg::NW;
    localparam int PW = dwfs_pkg::PROD_W;

    dwfs_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    logic [NW-1:0] r_eff_cfg;

    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [1:0]    r_k, n_k;
    logic [MW-1:0] r_lo [3];
    logic [MW-1:0] n_lo [3];
    logic [MW-1:0] r_hi [3];
    logic [MW-1:0] n_hi [3];
    logic [MW-1:0] r_gap [3];
    logic [MW-1:0] n_gap [3];
    logic [VW-1:0] r_v [3];
    logic [VW-1:0] n_v [3];
    dwfs_pkg::t_norm_word r_nrow, n_nrow, r_ni, n_ni;
    logic [SW-1:0] r_acc, n_acc, r_best, n_best;
    logic [AW-1:0] r_bi, n_bi;
    dwfs_pkg::t_out_beat r_out, n_out;

    logic [NW-1:0]        eff;
    logic                 in_acc, store;
    dwfs_pkg::t_raw_word  raw_wdata, raw_q;
    logic [AW-1:0]        raw_raddr, nrm_raddr;
    logic                 nrm_we;
    dwfs_pkg::t_norm_word nrm_q;
    logic [MW-1:0]        mul_a;
    logic [NW-1:0]        mul_b;
    logic [PW-1:0]        mul_p;
    dwfs_pkg::t_div_req   div_req;
    logic                 div_done;
    logic [NW-1:0]        div_quot;
    logic                 vzero, can_load;

    assign eff = (r_eff_cfg > dwfs_pkg::Q_ONE) ? dwfs_pkg::Q_ONE : r_eff_cfg;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != dwfs_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign store       = !i_in_data.is_arrival_face && (r_count < CW'(MaxFaces));
    assign vzero       = (r_v[0] == '0) && (r_v[1] == '0) && (r_v[2] == '0);
    assign can_load    = !r_out_valid || !i_out_stall;

    assign raw_wdata.face_id       = i_in_data.face_id;
    assign raw_wdata.status_level  = i_in_data.status_level;
    assign raw_wdata.rtt_ns        = i_in_data.rtt_ns;
    assign raw_wdata.pending_value = i_in_data.pending_value;

    assign raw_raddr = (r_state == dwfs_pkg::S_ID_RD || r_state == dwfs_pkg::S_EMIT) ?
                       r_bi : r_i[AW-1:0];
    assign nrm_raddr = (r_state == dwfs_pkg::S_PD_RDJ) ? r_j[AW-1:0] : r_i[AW-1:0];
    assign nrm_we    = (r_state == dwfs_pkg::S_NM_WR);

    dwfs_ram #(.Width($bits(dwfs_pkg::t_raw_word)), .Depth(MaxFaces)) u_raw_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && store),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (raw_wdata),
        .i_raddr (raw_raddr),
        .o_rdata (raw_q)
    );

    dwfs_ram #(.Width($bits(dwfs_pkg::t_norm_word)), .Depth(MaxFaces)) u_nrm_ram (
        .i_clk   (i_clk),
        .i_we    (nrm_we),
        .i_waddr (r_i[AW-1:0]),
        .i_wdata (r_nrow),
        .i_raddr (nrm_raddr),
        .o_rdata (nrm_q)
    );

    always_comb begin
        if (r_state == dwfs_pkg::S_SC_MUL) begin
            mul_a = MW'(r_v[r_k]);
            mul_b = nrm_q[r_k];
        end else begin
            mul_a = r_hi[r_k] - dwfs_pkg::raw_metric(raw_q, r_k);
            mul_b = eff;
        end
    end

    dwfs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign div_req.start = (r_state == dwfs_pkg::S_NM_DST);
    assign div_req.num   = mul_p;
    assign div_req.den   = r_gap[r_k];

    dwfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        logic [MW-1:0] x;
        logic [NW-1:0] d;
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_gap       = r_gap;
        n_v         = r_v;
        n_nrow      = r_nrow;
        n_ni        = r_ni;
        n_acc       = r_acc;
        n_best      = r_best;
        n_bi        = r_bi;
        x           = '0;
        d           = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            dwfs_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (store) begin
                        n_count = r_count + CW'(1);
                    end else if (!i_in_data.is_arrival_face) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last) begin
                        if (n_count == '0) begin
                            n_ovf = 1'b0;
                        end else begin
                            n_i     = '0;
                            n_state = dwfs_pkg::S_MM_RD;
                        end
                    end
                end
            end
            dwfs_pkg::S_MM_RD: begin
                n_state = dwfs_pkg::S_MM_ACC;
            end
            dwfs_pkg::S_MM_ACC: begin
                for (int k = 0; k < 3; k++) begin
                    x = dwfs_pkg::raw_metric(raw_q, 2'(k));
                    if (r_i == '0 || x < r_lo[k]) n_lo[k] = x;
                    if (r_i == '0 || x > r_hi[k]) n_hi[k] = x;
                end
                if (CW'(r_i + CW'(1)) == r_count) begin
                    n_state = dwfs_pkg::S_GAP;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = dwfs_pkg::S_MM_RD;
                end
            end
            dwfs_pkg::S_GAP: begin
                for (int k = 0; k < 3; k++) begin
                    n_gap[k] = (r_hi[k] == r_lo[k]) ? MW'(1) : (r_hi[k] - r_lo[k]);
                    n_v[k]   = '0;
                end
                n_i     = '0;
                n_k     = '0;
                n_state = dwfs_pkg::S_NM_RD;
            end
            dwfs_pkg::S_NM_RD: begin
                n_k     = '0;
                n_state = dwfs_pkg::S_NM_MUL;
            end
            dwfs_pkg::S_NM_MUL: begin
                n_state = dwfs_pkg::S_NM_DST;
            end
            dwfs_pkg::S_NM_DST: begin
                n_state = dwfs_pkg::S_NM_DIV;
            end
            dwfs_pkg::S_NM_DIV: begin
                if (div_done) begin
                    n_nrow[r_k] = div_quot + (dwfs_pkg::Q_ONE - eff);
                    if (r_k == dwfs_pkg::MET_PV) begin
                        n_state = dwfs_pkg::S_NM_WR;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = dwfs_pkg::S_NM_MUL;
                    end
                end
            end
            dwfs_pkg::S_NM_WR: begin
                if (CW'(r_i + CW'(1)) == r_count) begin
                    n_i     = '0;
                    n_state = (r_count == CW'(1)) ? dwfs_pkg::S_SC_RD : dwfs_pkg::S_PD_RDI;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = dwfs_pkg::S_NM_RD;
                end
            end
            dwfs_pkg::S_PD_RDI: begin
                n_state = dwfs_pkg::S_PD_LDI;
            end
            dwfs_pkg::S_PD_LDI: begin
                n_ni    = nrm_q;
                n_j     = r_i + CW'(1);
                n_state = dwfs_pkg::S_PD_RDJ;
            end
            dwfs_pkg::S_PD_RDJ: begin
                n_state = dwfs_pkg::S_PD_ACC;
            end
            dwfs_pkg::S_PD_ACC: begin
                for (int k = 0; k < 3; k++) begin
                    d = (r_ni[k] > nrm_q[k]) ? (r_ni[k] - nrm_q[k]) : (nrm_q[k] - r_ni[k]);
                    n_v[k] = r_v[k] + VW'(d);
                end
                if (CW'(r_j + CW'(1)) == r_count) begin
                    if (CW'(r_i + CW'(2)) == r_count) begin
                        n_i     = '0;
                        n_state = dwfs_pkg::S_SC_RD;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = dwfs_pkg::S_PD_RDI;
                    end
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = dwfs_pkg::S_PD_RDJ;
                end
            end
            dwfs_pkg::S_SC_RD: begin
                n_acc   = '0;
                n_k     = '0;
                n_state = dwfs_pkg::S_SC_MUL;
            end
            dwfs_pkg::S_SC_MUL: begin
                if (vzero) begin
                    n_acc   = SW'(nrm_q[dwfs_pkg::MET_ST]);
                    n_state = dwfs_pkg::S_SC_CMP;
                end else begin
                    n_state = dwfs_pkg::S_SC_ADD;
                end
            end
            dwfs_pkg::S_SC_ADD: begin
                n_acc = r_acc + SW'(mul_p);
                if (r_k == dwfs_pkg::MET_PV) begin
                    n_state = dwfs_pkg::S_SC_CMP;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = dwfs_pkg::S_SC_MUL;
                end
            end
            dwfs_pkg::S_SC_CMP: begin
                if (r_i == '0 || r_acc > r_best) begin
                    n_best = r_acc;
                    n_bi   = r_i[AW-1:0];
                end
                if (CW'(r_i + CW'(1)) == r_count) begin
                    n_state = dwfs_pkg::S_ID_RD;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = dwfs_pkg::S_SC_RD;
                end
            end
            dwfs_pkg::S_ID_RD: begin
                n_state = dwfs_pkg::S_EMIT;
            end
            dwfs_pkg::S_EMIT: begin
                if (can_load) begin
                    n_out.chosen_face = raw_q.face_id;
                    n_out.overflowed  = r_ovf;
                    n_out_valid       = 1'b1;
                    n_count           = '0;
                    n_ovf             = 1'b0;
                    n_state           = dwfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dwfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dwfs_pkg::S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_eff_cfg   <= dwfs_pkg::EFF_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_eff_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_gap  <= n_gap;
        r_v    <= n_v;
        r_nrow <= n_nrow;
        r_ni   <= n_ni;
        r_acc  <= n_acc;
        r_best <= n_best;
        r_bi   <= n_bi;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ===== dv/tb_top.sv =====
// Testbench for deviation_weighted_face_selector: random and directed face sets,
// scoring predicted in the bench, results checked beat by beat. Depends on dwfs_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dwfs_pkg::*;

    localparam int NFACE = MAX_FACES_DEF;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [NW-1:0]      i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_beat           i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_beat          o_out_data;

    deviation_weighted_face_selector i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    // selector model state
    logic [NW-1:0]    eff_reg;
    logic [ID_W-1:0]  m_id [NFACE];
    logic [ST_W-1:0]  m_st [NFACE];
    logic [RTT_W-1:0] m_rtt [NFACE];
    logic [PV_W-1:0]  m_pv [NFACE];
    int               m_count;
    logic             m_ovf;

    t_in_beat  face_q [$];
    t_out_beat choice_q [$];
    int        errors;
    int        outstanding;
    bit        drv_done;

    function automatic void score_faces(input logic [63:0] raw [NFACE], input int n,
                                        input logic [16:0] e, output logic [16:0] nv [NFACE]);
        logic [63:0] lo, hi, gap;
        lo = raw[0];
        hi = raw[0];
        for (int i = 1; i < n; i++) begin
            if (raw[i] < lo) lo = raw[i];
            if (raw[i] > hi) hi = raw[i];
        end
        gap = (hi == lo) ? 64'd1 : hi - lo;
        for (int i = 0; i < n; i++) begin
            nv[i] = 17'(((hi - raw[i]) * e) / gap + (64'd65536 - e));
        end
    endfunction

    function automatic logic [63:0] spread(input logic [16:0] nv [NFACE], input int n);
        logic [63:0] s;
        s = 0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                s += (nv[i] > nv[j]) ? 64'(nv[i] - nv[j]) : 64'(nv[j] - nv[i]);
        return s;
    endfunction

    task automatic load_face(input t_in_beat b);
        logic [63:0] raw [3][NFACE];
        logic [16:0] nv [3][NFACE];
        logic [63:0] w [3];
        logic [63:0] tot, sc, best_sc;
        logic [16:0] e;
        int          best;
        t_out_beat   r;
        if (!b.is_arrival_face) begin
            if (m_count < NFACE) begin
                m_id[m_count]  = b.face_id;
                m_st[m_count]  = b.status_level;
                m_rtt[m_count] = b.rtt_ns;
                m_pv[m_count]  = b.pending_value;
                m_count++;
            end else begin
                m_ovf = 1'b1;
            end
        end
        if (!b.last) return;
        if (m_count > 0) begin
            e = (eff_reg > Q_ONE) ? Q_ONE : eff_reg;
            for (int i = 0; i < m_count; i++) begin
                raw[0][i] = 64'(m_st[i]);
                raw[1][i] = 64'(m_rtt[i]);
                raw[2][i] = 64'(m_pv[i]);
            end
            for (int k = 0; k < 3; k++) begin
                score_faces(raw[k], m_count, e, nv[k]);
                w[k] = spread(nv[k], m_count);
            end
            tot = w[0] + w[1] + w[2];
            best = 0;
            best_sc = 0;
            for (int i = 0; i < m_count; i++) begin
                sc = (tot == 0) ? 64'(nv[0][i])
                   : w[0] * nv[0][i] + w[1] * nv[1][i] + w[2] * nv[2][i];
                if (i == 0 || sc > best_sc) begin
                    best_sc = sc;
                    best = i;
                end
            end
            r.chosen_face = m_id[best];
            r.overflowed  = m_ovf;
            choice_q.push_back(r);
        end
        m_count = 0;
        m_ovf = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // input stall flag sampled at the rising edge, and the wait counters
    logic o_in_stall_s;
    int   out_wait;
    int   in_wait;

    // driver
    always @(negedge i_clk) begin
        int w;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall_s) begin
                w = $urandom_range(0, 6);
                if (face_q.size() > 0 && w == 0) begin
                    in_wait <= 0;
                    i_in_valid <= 1'b1;
                    i_in_data <= face_q.pop_front();
                end else begin
                    in_wait <= (w > 0) ? w - 1 : 0;
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (in_wait > 0) in_wait <= in_wait - 1;
                else if (face_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= face_q.pop_front();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        o_in_stall_s <= o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) load_face(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (choice_q.size() == 0) begin
                $display("%0t: unexpected beat, actual id %h ovf %b", $time,
                         o_out_data.chosen_face, o_out_data.overflowed);
                errors++;
            end else begin
                t_out_beat x;
                x = choice_q.pop_front();
                if (x.chosen_face !== o_out_data.chosen_face)begin
                    $display("%0t: chosen_face expected %h actual %h", $time,
                             x.chosen_face, o_out_data.chosen_face);
                    errors++;
                end
                if (x.overflowed !== o_out_data.overflowed) begin
                    $display("%0t: overflowed expected %b actual %b", $time,
                             x.overflowed, o_out_data.overflowed);
                    errors++;
                end
            end
        end
    end

    // output stall: a drawn count of stalled cycles per result
    always @(negedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            out_wait = $urandom_range(0, 6);
            i_out_stall <= (out_wait > 0);
        end else if (i_out_stall) begin
            if (out_wait > 0) out_wait--;
            i_out_stall <= (out_wait > 0);
        end
    end

    function automatic t_in_beat rand_face(input bit lst, input int style);
        t_in_beat b;
        b.face_id = 16'($urandom);
        b.is_arrival_face = ($urandom_range(0, 9) == 0);
        b.status_level = 3'($urandom);
        case (style)
            0: b.rtt_ns = {8'($urandom), 32'($urandom)};
            default: b.rtt_ns = 40'($urandom_range(0, 50));
        endcase
        b.pending_value = (style == 0) ? 32'($urandom) : 32'($urandom_range(0, 20));
        b.last = lst;
        return b;
    endfunction

    task automatic add_set(input int n, input int style);
        for (int i = 0; i < n; i++) face_q.push_back(rand_face(i == n - 1, style));
    endtask

    task automatic wait_idle;
        while (face_q.size() > 0 || i_in_valid || choice_q.size() > 0) @(posedge i_clk);
        repeat (NFACE * NFACE + 80 * NFACE + 20) @(posedge i_clk);
    endtask

    task automatic write_eff(input logic [NW-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        eff_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_in_beat b;
        logic [NW-1:0] effs [5];
        errors = 0;
        m_count = 0;
        m_ovf = 1'b0;
        eff_reg = EFF_RESET;
        in_wait = 0;
        out_wait = 0;
        o_in_stall_s = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, single face, equal metrics, arrival-only, overflow
        b = '0;
        b.last = 1'b1;
        face_q.push_back(b);
        b = '1;
        face_q.push_back(b);
        b.is_arrival_face = 1'b0;
        face_q.push_back(b);
        b = '0; b.face_id = 16'h1111; b.status_level = 3'd7; face_q.push_back(b);
        b = '0; b.face_id = 16'h2222; b.rtt_ns = '1; b.pending_value = '1;
        face_q.push_back(b);
        b = '0; b.face_id = 16'h3333; b.last = 1'b1; face_q.push_back(b);
        b = '0; b.face_id = 16'hAAAA; face_q.push_back(b);
        b.face_id = 16'hBBBB; b.last = 1'b1; face_q.push_back(b);
        for (int i = 0; i < NFACE + 2; i++) begin
            b = rand_face(i == NFACE + 1, 1);
            b.is_arrival_face = 1'b0;
            face_q.push_back(b);
        end
        wait_idle();

        effs = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, EFF_RESET};
        for (int p = 0; p < 5; p++) begin
            write_eff(effs[p]);
            for (int it = 0; it < 170; ) begin
                int n;
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(NFACE, NFACE + 3)
                                                : $urandom_range(1, 6);
                add_set(n, $urandom_range(0, 1));
                it += n;
                if ($urandom_range(0, 20) == 0) begin
                    while (face_q.size() > 0 || choice_q.size() > 0) @(posedge i_clk);
                end
            end
            wait_idle();
        end

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== deviation_weighted_face_selector.f =====
hdl/dwfs_pkg.sv
hdl/dwfs_ram.sv
hdl/dwfs_mul.sv
hdl/dwfs_div.sv
hdl/deviation_weighted_face_selector.sv
dv/tb_top.sv
